// ----- design/ncfr_pkg.sv -----
package ncfr_pkg;

	localparam int BYTE_W    = 8;
	localparam int NIBBLE_W  = 4;
	localparam int TICK_W    = 16;
	localparam int KIND_W    = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// result kinds
	localparam kind_t KIND_PAYLOAD  = 3'd0;
	localparam kind_t KIND_OK       = 3'd1;
	localparam kind_t KIND_BADCHAR  = 3'd2;
	localparam kind_t KIND_BADCRC   = 3'd3;
	localparam kind_t KIND_OVERFLOW = 3'd4;
	localparam kind_t KIND_TIMEOUT  = 3'd5;

	// register indexes
	localparam cfg_idx_t REG_MAX_LENGTH    = 1'd0;
	localparam cfg_idx_t REG_TIMEOUT_TICKS = 1'd1;

	localparam logic [BYTE_W-1:0] MAX_LENGTH_RST    = 8'd255;
	localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;

	// line codes and crc polynomial
	localparam logic [BYTE_W-1:0]   LINE_STX    = 8'h02;
	localparam logic [BYTE_W-1:0]   LINE_ETX    = 8'h03;
	localparam logic [BYTE_W-1:0]   CRC_POLY    = 8'h8C;
	localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'h F;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic                seen_start;
		logic                seen_end;
		logic                expect_high;
		logic [NIBBLE_W-1:0] held_nibble;
		logic [BYTE_W-1:0]   byte_count;
		logic [BYTE_W-1:0]   running_crc;
		logic [TICK_W-1:0]   elapsed_ticks;
	} ncfr_state_t;

	localparam ncfr_state_t STATE_IDLE = '{
		seen_start:    1'b0,
		seen_end:      1'b0,
		expect_high:   1'b1,
		held_nibble:   '0,
		byte_count:    '0,
		running_crc:   '0,
		elapsed_ticks: '0
	};

	typedef struct packed {
		logic              emit;
		kind_t             result_kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] frame_length;
	} ncfr_result_t;

	// reflected crc-8, one data byte folded lsb first
	function automatic logic [BYTE_W-1:0] crc8_fold(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		logic [BYTE_W-1:0] d;
		c = crc;
		d = data;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

endpackage

// ----- design/ncfr_if.sv -----
interface ncfr_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface ncfr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] result_kind;
	logic [7:0] payload_byte;
	logic [7:0] frame_length;

	modport source (output valid, output result_kind, output payload_byte,
		output frame_length, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input frame_length, output ready);
endinterface

// ----- design/nibble_complement_frame_receiver_unit.sv -----
// channel | dir | payload                                   | transaction
// --------+-----+-------------------------------------------+-----------------------
// rx      | in  | operation, rx_byte                        | rx.valid & rx.ready
// res     | out | result_kind, payload_byte, frame_length   | res.valid & res.ready
// cfg     | in  | cfg_index, cfg_data                       | cfg_we
//
// one rx transaction per cycle; a result appears on res the cycle after its item
// the whole decode, nibble check and crc byte fold sit between the frame state
// register and the result register as combinational logic
// rx.ready drops only while a result sits in the result register and res stalls
// arst_n returns frame state to idle and registers to 255 and 1000
module nibble_complement_frame_receiver_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	ncfr_in_if.sink                  rx,
	ncfr_out_if.source               res,
	input  logic                     cfg_we,
	input  ncfr_pkg::cfg_idx_t       cfg_index,
	input  logic [ncfr_pkg::CFG_W-1:0] cfg_data
);
	import ncfr_pkg::*;

	// configuration registers
	logic [BYTE_W-1:0] max_length_q;
	logic [TICK_W-1:0] timeout_ticks_q;

	// frame state
	ncfr_state_t  state_q;
	ncfr_state_t  nxt_state;
	ncfr_result_t step_res;

	// result register
	logic         res_valid_q;
	ncfr_result_t res_q;

	logic rx_take;

	// accept while the result register is empty or being drained
	assign rx.ready = !res_valid_q || res.ready;
	assign rx_take  = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q    <= MAX_LENGTH_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_LENGTH:    max_length_q    <= cfg_data[BYTE_W-1:0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	ncfr_step u_step (
		.cur_state     (state_q),
		.operation     (rx.operation),
		.rx_byte       (rx.rx_byte),
		.max_length    (max_length_q),
		.timeout_ticks (timeout_ticks_q),
		.nxt_state     (nxt_state),
		.result        (step_res)
	);

	// frame state advances on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
		end else if (rx_take) begin
			state_q <= nxt_state;
		end
	end

	// output valid: set by an item that gives a result, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_take && step_res.emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (rx_take && step_res.emit) begin
			res_q <= step_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.result_kind  = res_q.result_kind;
	assign res.payload_byte = res_q.payload_byte;
	assign res.frame_length = res_q.frame_length;

endmodule

// ----- design/ncfr_step.sv -----
module ncfr_step (
	input  ncfr_pkg::ncfr_state_t  cur_state,
	input  logic                   operation,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             max_length,
	input  logic [15:0]            timeout_ticks,
	output ncfr_pkg::ncfr_state_t  nxt_state,
	output ncfr_pkg::ncfr_result_t result
);
	import ncfr_pkg::*;

	logic [NIBBLE_W-1:0] hi;
	logic [NIBBLE_W-1:0] lo;
	logic [BYTE_W-1:0]   full;
	logic [TICK_W-1:0]   elapsed_inc;

	assign hi          = rx_byte[BYTE_W-1:NIBBLE_W];
	assign lo          = rx_byte[NIBBLE_W-1:0];
	assign full        = {cur_state.held_nibble, hi};
	assign elapsed_inc = (cur_state.elapsed_ticks == '1) ? cur_state.elapsed_ticks
		: cur_state.elapsed_ticks + TICK_W'(1);

	always_comb begin
		nxt_state = cur_state;
		result    = '{emit: 1'b0, result_kind: KIND_PAYLOAD, payload_byte: '0,
			frame_length: '0};

		if (operation == OP_TICK) begin
			nxt_state.elapsed_ticks = elapsed_inc;
			if (elapsed_inc >= timeout_ticks) begin
				nxt_state          = STATE_IDLE;
				result.emit        = 1'b1;
				result.result_kind = KIND_TIMEOUT;
			end
		end else if (rx_byte == LINE_STX) begin
			nxt_state            = STATE_IDLE;
			nxt_state.seen_start = 1'b1;
		end else if (rx_byte == LINE_ETX) begin
			nxt_state.seen_end = 1'b1;
		end else if (cur_state.seen_start) begin
			if (hi != (lo ^ NIBBLE_MASK)) begin
				nxt_state          = STATE_IDLE;
				result.emit        = 1'b1;
				result.result_kind = KIND_BADCHAR;
			end else if (cur_state.expect_high) begin
				nxt_state.held_nibble = hi;
				nxt_state.expect_high = 1'b0;
			end else if (cur_state.seen_end) begin
				// decoded byte is the crc
				nxt_state   = STATE_IDLE;
				result.emit = 1'b1;
				if (cur_state.running_crc != full) begin
					result.result_kind = KIND_BADCRC;
				end else begin
					result.result_kind  = KIND_OK;
					result.frame_length = cur_state.byte_count;
				end
			end else if (cur_state.byte_count >= max_length) begin
				nxt_state          = STATE_IDLE;
				result.emit        = 1'b1;
				result.result_kind = KIND_OVERFLOW;
			end else begin
				nxt_state.expect_high = 1'b1;
				nxt_state.running_crc = crc8_fold(cur_state.running_crc, full);
				nxt_state.byte_count  = cur_state.byte_count + BYTE_W'(1);
				result.emit           = 1'b1;
				result.result_kind    = KIND_PAYLOAD;
				result.payload_byte   = full;
			end
		end
	end

endmodule

// ----- tb/testbench.sv -----
// checks the nibble-complement frame receiver against a cycle-free predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ncfr_pkg::*;

	// run limits
	localparam int unsigned CYCLE_LIMIT    = 1_000_000;
	localparam int          SETTLE_CYCLES  = 4;
	localparam int          HOLDOFF_CYCLES = 300;
	localparam int          PHASE_ITEMS    = 250;
	localparam int          LONG_TIMEOUT   = 120;
	localparam int          REPORT_LIMIT   = 10;

	typedef enum {STALL_OPEN, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	// one decoded result as the receiver should report it
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] payload;
		logic [BYTE_W-1:0] length;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                 cfg_we;
	cfg_idx_t             cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ncfr_in_if  rx_if ();
	ncfr_out_if res_if ();

	nibble_complement_frame_receiver_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the receiver registers and frame state
	logic [BYTE_W-1:0]   cfg_max_len;
	logic [TICK_W-1:0]   cfg_timeout;
	logic                frame_open;
	logic                end_marked;
	logic                want_high;
	logic [NIBBLE_W-1:0] upper_nib;
	logic [BYTE_W-1:0]   rx_count;
	logic [BYTE_W-1:0]   crc_acc;
	logic [TICK_W-1:0]   tick_count;

	// results still owed by the receiver, oldest first
	frame_result_t pending_results[$];

	// bookkeeping
	int          fail_count;
	int          sent_count;
	int          result_count;
	int          reg_writes;
	int          kind_seen[8];
	int unsigned cycle_count;

	// sender idling and receiver stall control
	bit          gaps_on;
	int          burst_left;
	stall_mode_t stall_mode;
	bit          holdoff_req;
	int          holdoff_left;
	logic [15:0] stall_bits;
	int          stall_pos;

	// what the last accepted transaction produced, for tests that wait on a status
	bit    last_hit;
	kind_t last_kind;

	// lsb-first crc-8, data folded in before the shifts
	function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] acc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = acc ^ data;
		repeat (BYTE_W) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic void clear_frame();
		frame_open = 1'b0;
		end_marked = 1'b0;
		want_high  = 1'b1;
		upper_nib  = '0;
		rx_count   = '0;
		crc_acc    = '0;
		tick_count = '0;
	endfunction

	// decode one line byte or tick; returns 1 when the receiver owes a result
	function automatic bit predict_step(input logic op, input logic [BYTE_W-1:0] b,
		output frame_result_t r);
		logic [BYTE_W-1:0] full;
		r = '0;
		if (op == OP_TICK) begin
			// tick counter saturates, timeout restarts from idle
			if (tick_count != '1)
				tick_count++;
			if (tick_count >= cfg_timeout) begin
				r.kind = KIND_TIMEOUT;
				clear_frame();
				return 1'b1;
			end
			return 1'b0;
		end
		if (b == LINE_STX) begin
			clear_frame();
			frame_open = 1'b1;
			return 1'b0;
		end
		// etx is taken anywhere, even outside a frame or between nibbles
		if (b == LINE_ETX) begin
			end_marked = 1'b1;
			return 1'b0;
		end
		if (!frame_open)
			return 1'b0;
		if (b[7:4] != ~b[3:0]) begin
			r.kind = KIND_BADCHAR;
			clear_frame();
			return 1'b1;
		end
		if (want_high) begin
			upper_nib = b[7:4];
			want_high = 1'b0;
			return 1'b0;
		end
		want_high = 1'b1;
		full = {upper_nib, b[7:4]};
		// after etx the decoded byte is the crc
		if (end_marked) begin
			if (crc_acc == full) begin
				r.kind   = KIND_OK;
				r.length = rx_count;
			end else begin
				r.kind = KIND_BADCRC;
			end
			clear_frame();
			return 1'b1;
		end
		if (rx_count >= cfg_max_len) begin
			r.kind = KIND_OVERFLOW;
			clear_frame();
			return 1'b1;
		end
		crc_acc = crc_update(crc_acc, full);
		rx_count++;
		r.kind    = KIND_PAYLOAD;
		r.payload = full;
		return 1'b1;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// result checker: every res transaction against the oldest expectation
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			result_count++;
			kind_seen[res_if.result_kind]++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result at cycle %0d: kind %0d byte %02h len %0d",
					cycle_count, res_if.result_kind, res_if.payload_byte, res_if.frame_length));
			end else begin
				want = pending_results.pop_front();
				if (res_if.result_kind !== want.kind || res_if.payload_byte !== want.payload
					|| res_if.frame_length !== want.length) begin
					note_failure($sformatf(
						"mismatch at cycle %0d: expected kind %0d byte %02h len %0d, got kind %0d byte %02h len %0d",
						cycle_count, want.kind, want.payload, want.length,
						res_if.result_kind, res_if.payload_byte, res_if.frame_length));
				end
			end
		end
	end

	// receiver side: long hold-off on request, otherwise its own stall pattern
	always @(posedge clk) begin
		if (holdoff_req) begin
			holdoff_left = HOLDOFF_CYCLES;
			holdoff_req  = 1'b0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			res_if.ready <= 1'b0;
		end else if (stall_mode == STALL_OPEN) begin
			res_if.ready <= 1'b1;
		end else begin
			res_if.ready <= stall_bits[stall_pos];
			stall_pos = (stall_pos + 1) % 16;
			// fresh pattern each time the sixteen-bit pattern is used up, biased by the mode
			if (stall_pos == 0)
				stall_bits = (stall_mode == STALL_LIGHT) ? 16'($urandom | $urandom)
					: 16'($urandom & $urandom);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// offer one item, wait for the transaction, then maybe idle
	task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
		frame_result_t r;
		bit            hit;
		int            gap;
		gap = 0;
		rx_if.valid     <= 1'b1;
		rx_if.operation <= op;
		rx_if.rx_byte   <= b;
		do @(posedge clk); while (!rx_if.ready);
		hit = predict_step(op, b, r);
		if (hit)
			pending_results.push_back(r);
		last_hit  = hit;
		last_kind = r.kind;
		sent_count++;
		// bursts of random length separated by random gaps
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 12);
				burst_left = $urandom_range(1, 16);
			end else begin
				burst_left--;
			end
		end
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one line character carrying nibble n and its complement
	task automatic send_code(input logic [NIBBLE_W-1:0] n);
		send_item(OP_BYTE, {n, ~n});
	endtask

	task automatic maybe_tick(input int tick_pct);
		if ($urandom_range(0, 99) < tick_pct)
			send_item(OP_TICK, 8'($urandom));
	endtask

	task automatic send_pair(input logic [BYTE_W-1:0] data, input int tick_pct);
		maybe_tick(tick_pct);
		send_code(data[7:4]);
		maybe_tick(tick_pct);
		send_code(data[3:0]);
	endtask

	// sender pause until every owed result is in, then let the block settle
	task automatic wait_idle();
		rx_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == REG_MAX_LENGTH)
			cfg_max_len = value[BYTE_W-1:0];
		else
			cfg_timeout = value;
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [BYTE_W-1:0] max_len, input logic [TICK_W-1:0] tmo);
		wait_idle();
		write_reg(REG_MAX_LENGTH, CFG_W'(max_len));
		write_reg(REG_TIMEOUT_TICKS, tmo);
	endtask

	// one frame with random content; mostly well formed, some broken
	task automatic send_random_frame(input int tick_pct);
		int                len;
		int                pick;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] crc;
		gaps_on    = ($urandom_range(0, 4) != 0);
		stall_mode = stall_mode_t'($urandom_range(0, 2));
		if ($urandom_range(0, 9) == 0)
			send_item(OP_BYTE, 8'($urandom));
		send_item(OP_BYTE, LINE_STX);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = $urandom_range(0, 6);
		else if (pick < 92)
			len = $urandom_range(7, 24);
		else if (cfg_max_len < 30)
			len = cfg_max_len + $urandom_range(0, 2);
		else
			len = $urandom_range(25, 40);
		crc = '0;
		for (int i = 0; i < len; i++) begin
			data = 8'($urandom);
			send_pair(data, tick_pct);
			crc = crc_update(crc, data);
		end
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			// a character that fails the complement check
			do data = 8'($urandom);
			while (data[7:4] == ~data[3:0] || data == LINE_STX || data == LINE_ETX);
			send_item(OP_BYTE, data);
		end else if (pick < 12) begin
			// frame abandoned, the next stx restarts
		end else if (pick < 20) begin
			// etx arrives between the two crc nibbles
			send_code(crc[7:4]);
			send_item(OP_BYTE, LINE_ETX);
			send_code(crc[3:0]);
		end else begin
			send_item(OP_BYTE, LINE_ETX);
			if (pick < 30)
				crc ^= 8'($urandom_range(1, 255));
			send_pair(crc, tick_pct);
		end
	endtask

	// reset defaults: ignored bytes, empty frame, restart, crc and char errors
	task automatic test_directed_framing();
		gaps_on    = 1'b1;
		stall_mode = STALL_LIGHT;
		// nothing before stx produces a result, etx only marks
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_code(4'h3);
		send_item(OP_BYTE, LINE_ETX);
		// empty frame reports ok with length zero
		send_item(OP_BYTE, LINE_STX);
		send_item(OP_BYTE, LINE_ETX);
		send_pair(8'h00, 0);
		// second stx throws away the first payload's crc
		send_item(OP_BYTE, LINE_STX);
		send_pair(8'hF0, 0);
		send_item(OP_BYTE, LINE_STX);
		send_pair(8'h00, 0);
		send_item(OP_BYTE, LINE_ETX);
		send_pair(crc_update(8'h00, 8'h00), 0);
		// etx with a high nibble held still switches to crc
		send_item(OP_BYTE, LINE_STX);
		send_code(4'hA);
		send_item(OP_BYTE, LINE_ETX);
		send_code(4'h5);
		// all-ones byte is not a nibble code
		send_item(OP_BYTE, LINE_STX);
		send_item(OP_BYTE, 8'hFF);
		wait_idle();
	endtask

	// maximum length zero and timeout one: every payload overflows, every tick times out
	task automatic test_limits_extremes();
		set_limits(8'd0, 16'd1);
		send_item(OP_BYTE, LINE_STX);
		send_pair(8'h12, 0);
		send_item(OP_TICK, 8'($urandom));
		wait_idle();
	endtask

	// receiver holds off while the sender keeps offering a long frame
	task automatic test_backpressure();
		logic [BYTE_W-1:0] data;
		set_limits(8'd40, 16'd1000);
		gaps_on     = 1'b0;
		stall_mode  = STALL_OPEN;
		holdoff_req = 1'b1;
		send_item(OP_BYTE, LINE_STX);
		// one past the limit ends in overflow
		for (int i = 0; i < 41; i++) begin
			data = 8'($urandom);
			send_pair(data, 0);
		end
		wait_idle();
	endtask

	// long timeout, ticks back to back until it fires
	task automatic test_long_timeout();
		int guard;
		set_limits(8'd255, TICK_W'(LONG_TIMEOUT));
		gaps_on    = 1'b0;
		stall_mode = STALL_OPEN;
		guard      = 0;
		do begin
			send_item(OP_TICK, 8'($urandom));
			guard++;
		end while (!(last_hit && last_kind == KIND_TIMEOUT) && guard < 4 * LONG_TIMEOUT);
		wait_idle();
	endtask

	// random traffic under several register settings
	task automatic test_random_traffic();
		logic [BYTE_W-1:0] max_set[5];
		logic [TICK_W-1:0] tmo_set[5];
		int                tick_set[5];
		int                phase_end;
		int                pick;
		max_set  = '{8'd255, 8'd0, 8'($urandom_range(1, 8)), 8'd255, 8'($urandom)};
		tmo_set  = '{16'd1000, 16'd1, 16'($urandom_range(2, 40)), 16'hFFFF,
			16'($urandom_range(1, 200))};
		tick_set = '{3, 5, 10, 3, $urandom_range(0, 15)};
		for (int p = 0; p < 5; p++) begin
			set_limits(max_set[p], tmo_set[p]);
			phase_end = sent_count + PHASE_ITEMS;
			while (sent_count < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					send_random_frame(tick_set[p]);
				end else if (pick < 95) begin
					// raw noise: bytes and ticks of any value
					repeat ($urandom_range(1, 4))
						send_item(1'($urandom_range(0, 1)), 8'($urandom));
				end else begin
					wait_idle();
				end
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n          = 1'b0;
		rx_if.valid     = 1'b0;
		rx_if.operation = OP_BYTE;
		rx_if.rx_byte   = '0;
		res_if.ready    = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_MAX_LENGTH;
		cfg_data        = '0;
		cfg_max_len     = MAX_LENGTH_RST;
		cfg_timeout     = TIMEOUT_TICKS_RST;
		clear_frame();
		fail_count   = 0;
		sent_count   = 0;
		result_count = 0;
		reg_writes   = 0;
		cycle_count  = 0;
		gaps_on      = 1'b1;
		burst_left   = 0;
		stall_mode   = STALL_OPEN;
		holdoff_req  = 1'b0;
		holdoff_left = 0;
		stall_bits   = '1;
		stall_pos    = 0;
		last_hit     = 1'b0;
		last_kind    = KIND_PAYLOAD;
		foreach (kind_seen[k])
			kind_seen[k] = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_framing();
		test_limits_extremes();
		test_backpressure();
		test_long_timeout();
		test_random_traffic();

		// anything still owed now never arrived
		if (pending_results.size() != 0)
			note_failure($sformatf("%0d expected results never arrived", pending_results.size()));

		$display("covered %0d rx transactions, %0d results: %0d payload, %0d ok, %0d bad char",
			sent_count, result_count, kind_seen[KIND_PAYLOAD], kind_seen[KIND_OK],
			kind_seen[KIND_BADCHAR]);
		$display("  %0d bad crc, %0d overflow, %0d timeout; %0d register writes; %0d failures",
			kind_seen[KIND_BADCRC], kind_seen[KIND_OVERFLOW], kind_seen[KIND_TIMEOUT],
			reg_writes, fail_count);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
